### sv/sce_pkg.sv
`default_nettype none

package sce_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register field widths
    localparam int GAIN_W  = 16;
    localparam int FLOOR_W = 12;
    localparam int FRAC_W  = 8;

    // fixed scalings: gains are Q0.16, threshold fraction is Q0.8
    localparam int GAIN_SHIFT = 16;
    localparam int FRAC_SHIFT = 8;

    // shared multiplier: unsigned A times signed B
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 33;
    localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;

    localparam int COUNT_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE             = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_GAIN        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_GAIN        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_FLOOR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_FRACTION = 3'd4;

    // register reset values
    localparam logic [GAIN_W-1:0]  OFFSET_GAIN_RST = 16'd13;
    localparam logic [GAIN_W-1:0]  FILTER_GAIN_RST = 16'd13107;
    localparam logic [FLOOR_W-1:0] FLOOR_RST       = 12'd100;
    localparam logic [FRAC_W-1:0]  FRACTION_RST    = 8'd64;

    // hysteresis sign codes
    localparam logic signed [1:0] SIGN_NONE = 2'sb00;
    localparam logic signed [1:0] SIGN_POS  = 2'sb01;
    localparam logic signed [1:0] SIGN_NEG  = 2'sb11;

    // exponential average being worked on, in update order
    localparam logic [1:0] EMA_SIN_OFF = 2'd0;
    localparam logic [1:0] EMA_COS_OFF = 2'd1;
    localparam logic [1:0] EMA_SIN_FLT = 2'd2;
    localparam logic [1:0] EMA_COS_FLT = 2'd3;

    typedef struct packed {
        logic               enable;
        logic [GAIN_W-1:0]  offset_gain;
        logic [GAIN_W-1:0]  filter_gain;
        logic [FLOOR_W-1:0] threshold_floor;
        logic [FRAC_W-1:0]  threshold_fraction;
    } t_cfg;

    // controller to datapath commands
    typedef struct packed {
        logic       load_in;
        logic       diff;
        logic       mul_lo;
        logic       mul_hi;
        logic       acc_hi;
        logic       upd;
        logic [1:0] ema_sel;
        logic       abs_en;
        logic       sq_s;
        logic       sq_c;
        logic       sq_acc;
        logic       sqrt_step;
        logic       thr_mul;
        logic       thr;
        logic       decide;
        logic       out_load;
    } t_cmd;

    // root bits for the magnitude: squared operands are held to 31 bits
    function automatic int sqrt_steps(input int w);
        int as_w;
        as_w = (w > 31) ? 31 : w;
        return as_w + 1;
    endfunction

endpackage

`default_nettype wire

### sv/sincos_encoder_cycle_counter.sv
// A word accepted while enabled is run through the four averages, the magnitude (R root
// digits, where R is SAMPLE_BITS + FRACTION_BITS + 1, at most 32), the threshold and the
// sign decision; while disabled it goes straight to the result word.
// The work is shared by the 32x33 multiplier and the one-digit-per-cycle square root unit;
// a new word is taken only after the last result is loaded. Reset (synchronous, active low) restores the
// register defaults and clears offsets, filters, sign state and the cycle count.
`default_nettype none

module sincos_encoder_cycle_counter #(
    parameter int SAMPLE_BITS   = 12,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [sce_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [sce_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [SAMPLE_BITS-1:0]          i_sin_sample,
    input  wire logic [SAMPLE_BITS-1:0]          i_cos_sample,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [sce_pkg::COUNT_W-1:0]          o_cycle_count,
    output logic signed [1:0]                    o_polarity,
    output logic                                 o_cycle_seen
);
    import sce_pkg::*;

    localparam int SQRT_STEPS = sqrt_steps(SAMPLE_BITS + FRACTION_BITS);

    t_cfg cfg;
    t_cmd cmd;
    logic clear;

    sce_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_clear     (clear)
    );

    sce_ctrl #(
        .SQRT_STEPS (SQRT_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_enable    (cfg.enable),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    sce_dpath #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_clear       (clear),
        .i_cmd         (cmd),
        .i_sin_sample  (i_sin_sample),
        .i_cos_sample  (i_cos_sample),
        .o_cycle_count (o_cycle_count),
        .o_polarity    (o_polarity),
        .o_cycle_seen  (o_cycle_seen)
    );

endmodule

`default_nettype wire

### sv/sce_cfg.sv
`default_nettype none

module sce_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [sce_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [sce_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output sce_pkg::t_cfg                        o_cfg,
    output logic                                 o_clear
);
    import sce_pkg::*;

    t_cfg r_cfg;

    // register file, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable             <= 1'b0;
            r_cfg.offset_gain        <= OFFSET_GAIN_RST;
            r_cfg.filter_gain        <= FILTER_GAIN_RST;
            r_cfg.threshold_floor    <= FLOOR_RST;
            r_cfg.threshold_fraction <= FRACTION_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ENABLE:             r_cfg.enable <= i_cfg_data[0];
                REG_OFFSET_GAIN:        r_cfg.offset_gain <= i_cfg_data[GAIN_W-1:0];
                REG_FILTER_GAIN:        r_cfg.filter_gain <= i_cfg_data[GAIN_W-1:0];
                REG_THRESHOLD_FLOOR:    r_cfg.threshold_floor <= i_cfg_data[FLOOR_W-1:0];
                REG_THRESHOLD_FRACTION: r_cfg.threshold_fraction <= i_cfg_data[FRAC_W-1:0];
                default: ;
            endcase
        end
    end

    // rising enable wipes the tracking state
    assign o_clear = i_cfg_we && (i_cfg_index == REG_ENABLE) && i_cfg_data[0]
                     && !r_cfg.enable;
    assign o_cfg   = r_cfg;

endmodule

`default_nettype wire

### sv/sce_ctrl.sv
`default_nettype none

module sce_ctrl #(
    parameter int SQRT_STEPS = 29
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_enable,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output sce_pkg::t_cmd o_cmd
);
    import sce_pkg::*;

    localparam int CNT_W = $clog2(SQRT_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SQRT_STEPS - 1);

    typedef enum logic [14:0] {
        S_IDLE    = 15'b000_0000_0000_0001,
        S_DIFF    = 15'b000_0000_0000_0010,
        S_MUL_LO  = 15'b000_0000_0000_0100,
        S_MUL_HI  = 15'b000_0000_0000_1000,
        S_ACC_HI  = 15'b000_0000_0001_0000,
        S_UPD     = 15'b000_0000_0010_0000,
        S_ABS     = 15'b000_0000_0100_0000,
        S_SQ_S    = 15'b000_0000_1000_0000,
        S_SQ_C    = 15'b000_0001_0000_0000,
        S_SQ_ACC  = 15'b000_0010_0000_0000,
        S_SQRT    = 15'b000_0100_0000_0000,
        S_THR_MUL = 15'b000_1000_0000_0000,
        S_THR     = 15'b001_0000_0000_0000,
        S_DECIDE  = 15'b010_0000_0000_0000,
        S_FINISH  = 15'b100_0000_0000_0000
    } t_state;

    t_state           r_state, n_state;
    logic [1:0]       r_idx;
    logic [CNT_W-1:0] r_cnt;
    logic             r_out_valid;

    // sequencing: four averages, magnitude, threshold, sign decision (all skipped when disabled)
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.ema_sel = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = i_enable ? S_DIFF : S_FINISH;
                end
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = S_MUL_LO;
            end
            S_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_ACC_HI;
            end
            S_ACC_HI: begin
                o_cmd.acc_hi = 1'b1;
                n_state      = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = (r_idx == EMA_COS_FLT) ? S_ABS : S_DIFF;
            end
            S_ABS: begin
                o_cmd.abs_en = 1'b1;
                n_state      = S_SQ_S;
            end
            S_SQ_S: begin
                o_cmd.sq_s = 1'b1;
                n_state    = S_SQ_C;
            end
            S_SQ_C: begin
                o_cmd.sq_c = 1'b1;
                n_state    = S_SQ_ACC;
            end
            S_SQ_ACC: begin
                o_cmd.sq_acc = 1'b1;
                n_state      = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_THR_MUL;
                end
            end
            S_THR_MUL: begin
                o_cmd.thr_mul = 1'b1;
                n_state       = S_THR;
            end
            S_THR: begin
                o_cmd.thr = 1'b1;
                n_state   = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state, average index, root step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= EMA_SIN_OFF;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_in) begin
                r_idx <= EMA_SIN_OFF;
            end else if (o_cmd.upd) begin
                r_idx <= r_idx + 2'd1;
            end
            if (o_cmd.sq_acc) begin
                r_cnt <= '0;
            end else if (o_cmd.sqrt_step) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    // result word held until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // a new result never overwrites one that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result word overwritten");

    // root step count never passes the last root step
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT) |-> (r_cnt <= CNT_LAST))
        else $error("root step counter out of range");

    // all four averages done before the magnitude is taken
    a_idx_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ABS) |-> (r_idx == EMA_SIN_OFF))
        else $error("average sequence incomplete");

endmodule

`default_nettype wire

### sv/sce_dpath.sv
`default_nettype none

module sce_dpath #(
    parameter int SAMPLE_BITS   = 12,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire sce_pkg::t_cfg                    i_cfg,
    input  wire logic                             i_clear,
    input  wire sce_pkg::t_cmd                    i_cmd,
    input  wire logic [SAMPLE_BITS-1:0]           i_sin_sample,
    input  wire logic [SAMPLE_BITS-1:0]           i_cos_sample,
    output logic [sce_pkg::COUNT_W-1:0]           o_cycle_count,
    output logic signed [1:0]                     o_polarity,
    output logic                                  o_cycle_seen
);
    import sce_pkg::*;

    localparam int W          = SAMPLE_BITS + FRACTION_BITS;
    localparam int FLT_W      = W + 1;
    localparam int D_W        = W + 2;
    localparam int DW_W       = 2 * MUL_A_W;
    localparam int K          = (W > 31) ? W - 31 : 0;
    localparam int AS_W       = W - K;
    localparam int ROOT_W     = sqrt_steps(W);
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 2;
    localparam int CAT_W      = REM_W + 2;
    localparam int FLOOR_SH_W = FLOOR_W + FRACTION_BITS;
    localparam int THR_W      = (FLT_W > FLOOR_SH_W) ? FLT_W : FLOOR_SH_W;
    localparam int CMP_W      = THR_W + 2;

    // tracking state
    logic [W-1:0]              r_off_s, r_off_c;
    logic signed [FLT_W-1:0]   r_flt_s, r_flt_c;
    logic signed [1:0]         r_cur, r_prev;
    logic [COUNT_W-1:0]        r_total;

    // working registers
    logic [W-1:0]              r_sin, r_cos;
    logic signed [D_W-1:0]     r_d;
    logic signed [PROD_W-1:0]  r_prod, r_acc;
    logic [AS_W-1:0]           r_abs_s, r_abs_c;
    logic [RAD_W-1:0]          r_rad;
    logic [REM_W-1:0]          r_rem;
    logic [ROOT_W-1:0]         r_root;
    logic [THR_W-1:0]          r_thr;
    logic                      r_seen;

    // result word
    logic [COUNT_W-1:0]        r_out_count;
    logic signed [1:0]         r_out_pol;
    logic                      r_out_seen;

    logic signed [D_W-1:0]     ema_tgt, ema_cur, n_d, n_upd;
    logic [GAIN_W-1:0]         ema_gain;
    logic signed [DW_W-1:0]    d_wide;
    logic [MUL_A_W-1:0]        mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  n_prod;
    logic signed [FLT_W-1:0]   abs_s_full, abs_c_full;
    logic [W-1:0]              mag_s, mag_c;
    logic [CAT_W-1:0]          sq_cat, sq_trial;
    logic [PROD_W-1:0]         thr_frac_full;
    logic [THR_W-1:0]          thr_frac, thr_floor;
    logic signed [CMP_W-1:0]   flt_cmp, thr_cmp, thr_neg;
    logic signed [1:0]         n_cur;
    logic                      n_hit;

    // average operands: target and current value of the selected average
    always_comb begin
        case (i_cmd.ema_sel)
            EMA_SIN_OFF: begin
                ema_tgt = $signed({2'b00, r_sin});
                ema_cur = $signed({2'b00, r_off_s});
            end
            EMA_COS_OFF: begin
                ema_tgt = $signed({2'b00, r_cos});
                ema_cur = $signed({2'b00, r_off_c});
            end
            EMA_SIN_FLT: begin
                ema_tgt = $signed({2'b00, r_sin}) - $signed({2'b00, r_off_s});
                ema_cur = $signed({r_flt_s[FLT_W-1], r_flt_s});
            end
            default: begin
                ema_tgt = $signed({2'b00, r_cos}) - $signed({2'b00, r_off_c});
                ema_cur = $signed({r_flt_c[FLT_W-1], r_flt_c});
            end
        endcase
        ema_gain = (i_cmd.ema_sel == EMA_SIN_OFF || i_cmd.ema_sel == EMA_COS_OFF)
                   ? i_cfg.offset_gain : i_cfg.filter_gain;
        n_d   = ema_tgt - ema_cur;
        n_upd = ema_cur + D_W'(r_acc >>> GAIN_SHIFT);
    end

    // shared multiplier operand select
    assign d_wide = DW_W'(r_d);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (i_cmd.mul_lo) begin
            mul_a = d_wide[MUL_A_W-1:0];
            mul_b = MUL_B_W'(ema_gain);
        end else if (i_cmd.mul_hi) begin
            mul_a = MUL_A_W'(ema_gain);
            mul_b = $signed({d_wide[DW_W-1], d_wide[DW_W-1:MUL_A_W]});
        end else if (i_cmd.sq_s) begin
            mul_a = MUL_A_W'(r_abs_s);
            mul_b = MUL_B_W'(r_abs_s);
        end else if (i_cmd.sq_c) begin
            mul_a = MUL_A_W'(r_abs_c);
            mul_b = MUL_B_W'(r_abs_c);
        end else if (i_cmd.thr_mul) begin
            mul_a = MUL_A_W'(r_root);
            mul_b = MUL_B_W'(i_cfg.threshold_fraction);
        end
        n_prod = $signed({1'b0, mul_a}) * mul_b;
    end

    // magnitudes of the filtered signals, scaled to fit the squarer
    always_comb begin
        abs_s_full = r_flt_s[FLT_W-1] ? -r_flt_s : r_flt_s;
        abs_c_full = r_flt_c[FLT_W-1] ? -r_flt_c : r_flt_c;
        mag_s      = abs_s_full[W-1:0];
        mag_c      = abs_c_full[W-1:0];
    end

    // one root digit per step
    assign sq_cat   = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign sq_trial = CAT_W'({r_root, 2'b01});

    // threshold and sign decision
    always_comb begin
        thr_frac_full = (r_prod <<< K) >>> FRAC_SHIFT;
        thr_frac      = THR_W'(thr_frac_full);
        thr_floor     = THR_W'({i_cfg.threshold_floor, {FRACTION_BITS{1'b0}}});
        flt_cmp       = CMP_W'(r_flt_s);
        thr_cmp       = $signed(CMP_W'(r_thr));
        thr_neg       = -thr_cmp;
        n_cur         = r_cur;
        if (flt_cmp > thr_cmp) begin
            n_cur = SIGN_POS;
        end else if (flt_cmp < thr_neg) begin
            n_cur = SIGN_NEG;
        end
        n_hit = (r_prev == SIGN_NEG) && (n_cur == SIGN_POS);
    end

    // tracking state, wiped by reset or a rising enable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_off_s <= '0;
            r_off_c <= '0;
            r_flt_s <= '0;
            r_flt_c <= '0;
            r_cur   <= SIGN_NONE;
            r_prev  <= SIGN_NONE;
            r_total <= '0;
        end else begin
            if (i_cmd.upd) begin
                case (i_cmd.ema_sel)
                    EMA_SIN_OFF: r_off_s <= W'(n_upd);
                    EMA_COS_OFF: r_off_c <= W'(n_upd);
                    EMA_SIN_FLT: r_flt_s <= FLT_W'(n_upd);
                    default:     r_flt_c <= FLT_W'(n_upd);
                endcase
            end
            if (i_cmd.decide) begin
                r_cur <= n_cur;
                if (n_cur != SIGN_NONE) begin
                    r_prev <= n_cur;
                end
                if (n_hit) begin
                    r_total <= r_total + COUNT_W'(1);
                end
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_sin  <= {i_sin_sample, {FRACTION_BITS{1'b0}}};
            r_cos  <= {i_cos_sample, {FRACTION_BITS{1'b0}}};
            r_seen <= 1'b0;
        end
        if (i_cmd.decide) begin
            r_seen <= n_hit;
        end
        if (i_cmd.diff) begin
            r_d <= n_d;
        end
        if (i_cmd.mul_lo || i_cmd.mul_hi || i_cmd.sq_s || i_cmd.sq_c || i_cmd.thr_mul) begin
            r_prod <= n_prod;
        end
        // low partial product first, high one lands 32 bits up
        if (i_cmd.mul_hi || i_cmd.sq_c) begin
            r_acc <= r_prod;
        end else if (i_cmd.acc_hi) begin
            r_acc <= r_acc + (r_prod <<< MUL_A_W);
        end
        if (i_cmd.abs_en) begin
            r_abs_s <= AS_W'(mag_s >> K);
            r_abs_c <= AS_W'(mag_c >> K);
        end
        if (i_cmd.sq_acc) begin
            r_rad  <= RAD_W'(r_acc + r_prod);
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_rad <= r_rad << 2;
            if (sq_cat >= sq_trial) begin
                r_rem  <= REM_W'(sq_cat - sq_trial);
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= REM_W'(sq_cat);
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
        if (i_cmd.thr) begin
            r_thr <= (thr_frac < thr_floor) ? thr_floor : thr_frac;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_count <= r_total;
            r_out_pol   <= r_cur;
            r_out_seen  <= r_seen;
        end
    end

    assign o_cycle_count = r_out_count;
    assign o_polarity    = r_out_pol;
    assign o_cycle_seen  = r_out_seen;

    // once a side is decided the previous sign follows the current one
    a_sign_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur != SIGN_NONE) |-> (r_prev == r_cur))
        else $error("previous sign lost track of current sign");

    // root remainder never exceeds twice the partial root
    a_root_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sqrt_step |-> (REM_W'(r_rem) <= REM_W'({r_root, 1'b0})))
        else $error("square root remainder out of range");

endmodule

`default_nettype wire
